// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the deque RTL; sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define BDQS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies the consequence in the next cycle
`define BDQS_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// bdqs_pkg
// Types and constants shared by the bounded deque with search.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    // Default number of entries
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Match bits examined per scan cycle (power of two)
    localparam int SCAN_GROUP = 8;

    // Request codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_MISS  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Per-cell control for one cycle
    typedef struct packed {
        logic shift_up;    // take left neighbor (push front)
        logic shift_down;  // take right neighbor (pop front)
        logic load;        // take the item value (push back into this slot)
        logic cmp;         // capture a compare against the item value
        logic held;        // this slot holds an entry
    } cell_ctrl_t;

    // Scanner status
    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

// File: rtl/bdqs_if.sv
// ----------------------------------------------------------------------------
// bdqs_if
// Valid/ready channels for requests and results of the deque.
// ----------------------------------------------------------------------------

// Request channel
interface bdqs_in_if;
    logic                               valid;
    logic                               ready;
    logic [bdqs_pkg::CMD_W-1:0]         cmd;
    logic signed [bdqs_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel
interface bdqs_out_if #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
);
    localparam int PW = $clog2(DEPTH + 1);

    logic                          valid;
    logic                          ready;
    logic [bdqs_pkg::STATUS_W-1:0] status;
    logic [PW-1:0]                 position;
    logic [PW-1:0]                 occupancy;

    modport source (output valid, output status, output position, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    output ready);
endinterface

// File: rtl/bdqs_cell.sv
// ----------------------------------------------------------------------------
// bdqs_cell
// One deque slot: holds an entry, shifts with its neighbors, compares a key.
// ----------------------------------------------------------------------------
module bdqs_cell (
    input  logic                               clk,
    input  bdqs_pkg::cell_ctrl_t               ctrl,
    input  logic signed [bdqs_pkg::DATA_W-1:0] value,
    input  logic signed [bdqs_pkg::DATA_W-1:0] left,
    input  logic signed [bdqs_pkg::DATA_W-1:0] right,
    output logic signed [bdqs_pkg::DATA_W-1:0] data,
    output logic                               match
);

    logic signed [bdqs_pkg::DATA_W-1:0] data_reg;
    logic signed [bdqs_pkg::DATA_W-1:0] data_next;
    logic                               match_reg;
    logic                               match_next;

    // Slot update
    always_comb
    begin
        if (ctrl.load)
        begin
            data_next = value;
        end
        else if (ctrl.shift_up)
        begin
            data_next = left;
        end
        else if (ctrl.shift_down)
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
        match_next = ctrl.cmp ? (ctrl.held && (data_reg == value)) : match_reg;
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// File: rtl/bdqs_scan.sv
// ----------------------------------------------------------------------------
// bdqs_scan
// Finds the first set match bit from the front, one group of bits per cycle.
// ----------------------------------------------------------------------------
module bdqs_scan #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         run,
    input  logic [DEPTH-1:0]             match,
    output bdqs_pkg::scan_stat_t         stat,
    output logic [$clog2(DEPTH+1)-1:0]   pos
);

    localparam int PW    = $clog2(DEPTH + 1);
    localparam int GROUP = bdqs_pkg::SCAN_GROUP;
    localparam int GB    = $clog2(GROUP);
    localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PADW  = NGRP * GROUP;

    logic [GW-1:0]    grp_reg;
    logic [GW-1:0]    grp_next;
    logic [PADW-1:0]  padded;
    logic [GROUP-1:0] grp_bits;
    logic             hit;
    logic [GB-1:0]    off;
    logic             last;

    // Current group of match bits, tail padded with zeros
    assign padded   = PADW'(match);
    assign grp_bits = padded[GROUP*grp_reg +: GROUP];
    assign last     = (grp_reg == GW'(NGRP - 1));

    // Lowest set bit within the group
    always_comb
    begin
        hit = 1'b0;
        off = '0;
        for (int k = GROUP - 1; k >= 0; k--)
        begin
            if (grp_bits[k])
            begin
                hit = 1'b1;
                off = GB'(k);
            end
        end
    end

    assign stat.done  = run && (hit || last);
    assign stat.found = run && hit;
    assign pos        = PW'({grp_reg, off}) + PW'(1);

    // Group pointer
    always_comb
    begin
        if (start)
        begin
            grp_next = '0;
        end
        else if (run && !stat.done)
        begin
            grp_next = grp_reg + GW'(1);
        end
        else
        begin
            grp_next = grp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else
        begin
            grp_reg <= grp_next;
        end
    end

endmodule

// File: rtl/bounded_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded double-ended queue of signed 32-bit values with a search by value.
// ----------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells ordered front to back; pushes and
// front pops shift or load the cells, a back pop only lowers the count,
// and a push or pop result is registered at the accepting edge. A search
// compares the key in every cell at once, then a scanner walks the match
// bits eight per cycle from the front, stopping at the first hit; no
// request is taken while it runs. Results pass through a two-entry output
// buffer, so a request is taken while one result still waits downstream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_search_unit #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bdqs_in_if.sink     req,
    bdqs_out_if.source  rsp
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int DW = bdqs_pkg::DATA_W;

    bdqs_pkg::state_t      state_reg;
    bdqs_pkg::state_t      state_next;
    logic [PW-1:0]         count_reg;
    logic [PW-1:0]         count_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  do_pf;
    logic                  do_pb;
    logic                  do_popf;
    logic                  do_cmp;
    logic                  scan_start;
    logic                  scan_run;

    logic                  res_valid;
    bdqs_pkg::status_t     res_status;
    logic [PW-1:0]         res_pos;
    logic [PW-1:0]         res_occ;

    logic                  out_valid_reg;
    bdqs_pkg::status_t     out_status_reg;
    logic [PW-1:0]         out_pos_reg;
    logic [PW-1:0]         out_occ_reg;
    logic                  skid_valid_reg;
    bdqs_pkg::status_t     skid_status_reg;
    logic [PW-1:0]         skid_pos_reg;
    logic [PW-1:0]         skid_occ_reg;
    logic                  out_pop;

    bdqs_pkg::cell_ctrl_t  ctrl [DEPTH];
    logic signed [DW-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]      match_vec;
    bdqs_pkg::scan_stat_t  scan_stat;
    logic [PW-1:0]         scan_pos;

    // Handshake and occupancy flags
    assign req.ready = (state_reg == bdqs_pkg::ST_IDLE) && !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == PW'(DEPTH));
    assign empty     = (count_reg == '0);

    // Request decode, next state and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res_status = bdqs_pkg::STS_DONE;
        res_pos    = '0;
        res_occ    = count_reg;
        do_pf      = 1'b0;
        do_pb      = 1'b0;
        do_popf    = 1'b0;
        do_cmp     = 1'b0;
        scan_start = 1'b0;
        scan_run   = 1'b0;
        case (state_reg)
            bdqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    case (req.cmd)
                        bdqs_pkg::CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status = bdqs_pkg::STS_FULL;
                            end
                            else
                            begin
                                do_pf      = 1'b1;
                                count_next = count_reg + PW'(1);
                            end
                        end
                        bdqs_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status = bdqs_pkg::STS_FULL;
                            end
                            else
                            begin
                                do_pb      = 1'b1;
                                count_next = count_reg + PW'(1);
                            end
                        end
                        bdqs_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status = bdqs_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                do_popf    = 1'b1;
                                count_next = count_reg - PW'(1);
                            end
                        end
                        bdqs_pkg::CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status = bdqs_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - PW'(1);
                            end
                        end
                        bdqs_pkg::CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_status = bdqs_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                // result comes from the scan
                                res_valid  = 1'b0;
                                do_cmp     = 1'b1;
                                scan_start = 1'b1;
                                state_next = bdqs_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // unknown request: no change, plain done
                        end
                    endcase
                    res_occ = count_next;
                end
            end
            bdqs_pkg::ST_SCAN:
            begin
                scan_run = 1'b1;
                if (scan_stat.done)
                begin
                    res_valid  = 1'b1;
                    res_status = scan_stat.found ? bdqs_pkg::STS_DONE : bdqs_pkg::STS_MISS;
                    res_pos    = scan_stat.found ? scan_pos : '0;
                    state_next = bdqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdqs_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller state and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdqs_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Cell row, front entry in cell 0
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DW-1:0] left_w;
            logic signed [DW-1:0] right_w;

            assign ctrl[i] = '{
                shift_up:   do_pf,
                shift_down: do_popf,
                load:       do_pb && (count_reg == PW'(i)),
                cmp:        do_cmp,
                held:       (count_reg > PW'(i))
            };

            if (i == 0)
            begin : g_front
                assign left_w = req.value;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_back
                assign right_w = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[i+1];
            end

            bdqs_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl[i]),
                .value (req.value),
                .left  (left_w),
                .right (right_w),
                .data  (cell_data[i]),
                .match (match_vec[i])
            );
        end
    endgenerate

    // First-match scanner
    bdqs_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .run   (scan_run),
        .match (match_vec),
        .stat  (scan_stat),
        .pos   (scan_pos)
    );

    // Two-entry output buffer
    assign out_pop = out_valid_reg && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop && skid_valid_reg)
        begin
            out_status_reg <= skid_status_reg;
            out_pos_reg    <= skid_pos_reg;
            out_occ_reg    <= skid_occ_reg;
        end
        else if (res_valid && (out_pop || !out_valid_reg))
        begin
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
            out_occ_reg    <= res_occ;
        end
        if (res_valid && out_valid_reg && !out_pop)
        begin
            skid_status_reg <= res_status;
            skid_pos_reg    <= res_pos;
            skid_occ_reg    <= res_occ;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.position  = out_pos_reg;
    assign rsp.occupancy = out_occ_reg;

    // Checks
    `BDQS_ASSERT(a_no_skid_overrun, !(res_valid && skid_valid_reg), "result with skid full")
    `BDQS_ASSERT(a_count_bound, count_reg <= PW'(DEPTH), "entry count above depth")
    `BDQS_ASSERT_NEXT(a_search_scans, accept && (req.cmd == bdqs_pkg::CMD_SEARCH) && !empty, state_reg == bdqs_pkg::ST_SCAN, "search did not start scan")
    `BDQS_ASSERT_NEXT(a_scan_count, state_reg == bdqs_pkg::ST_SCAN, $stable(count_reg), "count moved during scan")

endmodule
